>>> src/pps_pkg.sv
package pps_pkg;

    typedef enum logic [2:0] {
        EV_ADDED = 3'd0,
        EV_FULL  = 3'd1,
        EV_ZERO  = 3'd2,
        EV_IDLE  = 3'd3,
        EV_RUN   = 3'd4,
        EV_DONE  = 3'd5
    } t_event;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> src/preemptive_priority_scheduler.sv
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_stall    | i_func, i_priority_req, i_arrival_time, i_burst
// output  | out       | o_valid / i_stall    | o_event_res, o_process_id, o_tick_time,
//         |           |                      | o_waiting_time, o_turnaround_time
// An add or a tick gives its result after a scan of the table: one table
// entry per cycle goes through the shared compare unit, then the chosen entry is fetched
// and updated. A zero-burst add gives its result in the cycle after acceptance.
// The next item can be taken in the cycle after the result is delivered, so an add or
// tick is finished before a new one is taken. Output stalls delay the next item.
// Reset is synchronous; it clears valid bits, time and stamp counters and sets the number counter to 1.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_arrival_time,
    input  logic [15:0] i_burst,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_process_id,
    output logic [31:0] o_tick_time,
    output logic [31:0] o_waiting_time,
    output logic [31:0] o_turnaround_time
);

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    // Slot memory, one word per field group.
    logic [15:0] m_number    [MAX_PROCESSES];
    logic [7:0]  m_priority  [MAX_PROCESSES];
    logic [31:0] m_ready     [MAX_PROCESSES];
    logic [15:0] m_remaining [MAX_PROCESSES];
    logic [31:0] m_waited    [MAX_PROCESSES];
    logic [15:0] m_burst     [MAX_PROCESSES];
    logic [31:0] m_stamp     [MAX_PROCESSES];

    logic [MAX_PROCESSES-1:0] r_valid_bits;
    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic        r_func;
    logic [7:0]  r_prio_in;
    logic [31:0] r_arr_in;
    logic [15:0] r_burst_in;
    logic [31:0] r_time;
    logic [15:0] r_next_num;
    logic [31:0] r_next_stamp;
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [7:0]  r_best_prio;
    logic [31:0] r_best_age;
    // Registered scan reads.
    logic        r_rd_ok;
    logic [IW-1:0] r_rd_idx;
    logic [7:0]  r_rd_prio;
    logic [31:0] r_rd_ready;
    logic [31:0] r_rd_stamp;
    // Registered fetch of the chosen entry.
    logic [15:0] r_f_num;
    logic [31:0] r_f_ready;
    logic [15:0] r_f_rem;
    logic [31:0] r_f_wait;
    logic [15:0] r_f_burst;
    logic        r_o_valid;
    logic [2:0]  r_o_event;
    logic [15:0] r_o_pid;
    logic [31:0] r_o_time;
    logic [31:0] r_o_wait;
    logic [31:0] r_o_turn;

    logic        in_acc;
    logic [IW-1:0] scan_idx;
    logic [31:0] rd_age;
    logic        better;
    logic [31:0] new_wait;
    logic [15:0] new_rem;

    assign o_stall = (r_state != ST_IDLE) || r_o_valid;
    assign in_acc  = i_valid && !o_stall;
    assign scan_idx = r_cnt[IW-1:0];

    // Shared compare unit: one candidate against the running best.
    assign rd_age = r_rd_stamp - r_next_stamp;
    always_comb begin
        better = 1'b0;
        if (r_rd_ok) begin
            if (r_func == FUNC_ADD) begin
                better = !r_found;
            end else if (r_rd_ready <= r_time) begin
                better = !r_found || (r_rd_prio < r_best_prio) ||
                         ((r_rd_prio == r_best_prio) && (rd_age < r_best_age));
            end
        end
    end

    assign new_wait = sat_add32(r_f_wait, r_time - r_f_ready);
    assign new_rem  = r_f_rem - 16'd1;

    // Memory reads, registered.
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= scan_idx;
        r_rd_prio  <= m_priority[scan_idx];
        r_rd_ready <= m_ready[scan_idx];
        r_rd_stamp <= m_stamp[scan_idx];
        r_f_num    <= m_number[r_best];
        r_f_ready  <= m_ready[r_best];
        r_f_rem    <= m_remaining[r_best];
        r_f_wait   <= m_waited[r_best];
        r_f_burst  <= m_burst[r_best];
    end

    // Memory writes for add and for a run.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY && r_found) begin
            if (r_func == FUNC_ADD) begin
                m_number[r_best]    <= r_next_num;
                m_priority[r_best]  <= r_prio_in;
                m_ready[r_best]     <= r_arr_in;
                m_remaining[r_best] <= r_burst_in;
                m_waited[r_best]    <= '0;
                m_burst[r_best]     <= r_burst_in;
                m_stamp[r_best]     <= r_next_stamp;
            end else begin
                m_waited[r_best]    <= new_wait;
                m_remaining[r_best] <= new_rem;
                m_ready[r_best]     <= r_time + 32'd1;
                m_stamp[r_best]     <= r_next_stamp;
            end
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid_bits <= '0;
            r_time       <= '0;
            r_next_num   <= 16'd1;
            r_next_stamp <= '0;
            r_o_valid    <= 1'b0;
            r_rd_ok      <= 1'b0;
            r_found      <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_ok <= 1'b0;
                    if (in_acc) begin
                        r_func     <= i_func;
                        r_prio_in  <= i_priority_req;
                        r_arr_in   <= i_arrival_time;
                        r_burst_in <= i_burst;
                        r_found    <= 1'b0;
                        r_cnt      <= '0;
                        if (i_func == FUNC_ADD && i_burst == 16'd0) begin
                            r_o_valid <= 1'b1;
                            r_o_event <= EV_ZERO;
                            r_o_pid   <= '0;
                            r_o_time  <= r_time;
                            r_o_wait  <= '0;
                            r_o_turn  <= '0;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (better) begin
                        r_found     <= 1'b1;
                        r_best      <= r_rd_idx;
                        r_best_prio <= r_rd_prio;
                        r_best_age  <= rd_age;
                    end
                    if (r_cnt == CW'(MAX_PROCESSES)) begin
                        r_rd_ok <= 1'b0;
                        r_state <= ST_FETCH;
                    end else begin
                        // An add looks for a free entry, a tick for an occupied one.
                        r_rd_ok <= (r_func == FUNC_ADD) ? !r_valid_bits[scan_idx]
                                                        : r_valid_bits[scan_idx];
                        r_cnt   <= r_cnt + CW'(1);
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    r_state   <= ST_IDLE;
                    r_o_valid <= 1'b1;
                    r_o_time  <= r_time;
                    if (r_func == FUNC_ADD) begin
                        r_o_wait <= '0;
                        r_o_turn <= '0;
                        if (r_found) begin
                            r_valid_bits[r_best] <= 1'b1;
                            r_o_event    <= EV_ADDED;
                            r_o_pid      <= r_next_num;
                            r_next_num   <= r_next_num + 16'd1;
                            r_next_stamp <= r_next_stamp + 32'd1;
                        end else begin
                            r_o_event <= EV_FULL;
                            r_o_pid   <= '0;
                        end
                    end else begin
                        r_time <= r_time + 32'd1;
                        if (!r_found) begin
                            r_o_event <= EV_IDLE;
                            r_o_pid   <= '0;
                            r_o_wait  <= '0;
                            r_o_turn  <= '0;
                        end else begin
                            r_o_pid <= r_f_num;
                            if (new_rem == 16'd0) begin
                                r_o_event <= EV_DONE;
                                r_o_wait  <= new_wait;
                                r_o_turn  <= sat_add32(new_wait, {16'd0, r_f_burst});
                                r_valid_bits[r_best] <= 1'b0;
                            end else begin
                                r_o_event    <= EV_RUN;
                                r_o_wait     <= '0;
                                r_o_turn     <= '0;
                                r_next_stamp <= r_next_stamp + 32'd1;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_event_res       = r_o_event;
    assign o_process_id      = r_o_pid;
    assign o_tick_time       = r_o_time;
    assign o_waiting_time    = r_o_wait;
    assign o_turnaround_time = r_o_turn;

    // A new item is never taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid || r_state != ST_IDLE) |-> o_stall)
        else $error("input accepted while busy");
    // Time advances only on a tick.
    a_time_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_APPLY) |=> $stable(r_time))
        else $error("time moved outside a tick");
    // The result register is loaded at the end of an item.
    a_out_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |=> r_o_valid)
        else $error("missing result");

endmodule

>>> sim/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 100ps

module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    localparam int NSLOTS      = 16;
    localparam int IDLE_PCT    = 37;
    localparam int NUM_RANDOM  = 2000;
    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 400;

    // One completion record as the block reports it.
    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] pid;
        logic [31:0] tick;
        logic [31:0] waited;
        logic [31:0] turnaround;
    } t_completion;

    // One stimulus row; has_exp marks rows whose result is typed in.
    typedef struct {
        logic        func;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic [15:0] burst;
        bit          has_exp;
        t_event      ev;
        logic [15:0] pid;
        logic [31:0] tick;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [7:0]  i_priority_req;
    logic [31:0] i_arrival_time;
    logic [15:0] i_burst;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_event_res;
    logic [15:0] o_process_id;
    logic [31:0] o_tick_time;
    logic [31:0] o_waiting_time;
    logic [31:0] o_turnaround_time;

    // Scheduler state mirrored by the predictor.
    bit          tbl_valid [NSLOTS];
    logic [15:0] tbl_number [NSLOTS];
    logic [7:0]  tbl_prio [NSLOTS];
    logic [31:0] tbl_ready [NSLOTS];
    logic [15:0] tbl_left [NSLOTS];
    logic [31:0] tbl_waited [NSLOTS];
    logic [15:0] tbl_burst [NSLOTS];
    logic [31:0] tbl_stamp [NSLOTS];
    logic [31:0] sched_now;
    logic [15:0] sched_next_pid;
    logic [31:0] sched_next_stamp;

    t_completion pending_results [$];
    int          errors;
    int          quiet_cycles;
    bit          drain_hold;
    bit          no_idle;
    bit          hold_done;

    preemptive_priority_scheduler u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_priority_req    (i_priority_req),
        .i_arrival_time    (i_arrival_time),
        .i_burst           (i_burst),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_res       (o_event_res),
        .o_process_id      (o_process_id),
        .o_tick_time       (o_tick_time),
        .o_waiting_time    (o_waiting_time),
        .o_turnaround_time (o_turnaround_time)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] add_saturating(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_schedule();
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        sched_now        = '0;
        sched_next_pid   = 16'd1;
        sched_next_stamp = '0;
    endfunction

    // Computes the completion of one transaction and updates the mirrored table.
    function automatic t_completion schedule_step(logic func, logic [7:0] prio,
                                                  logic [31:0] arrival, logic [15:0] burst);
        t_completion r;
        int          slot;
        logic [7:0]  best_prio;
        logic [31:0] best_age;
        logic [31:0] age;
        r      = '0;
        r.tick = sched_now;
        slot   = -1;
        if (func == FUNC_ADD) begin
            if (burst == 0) begin
                r.ev = EV_ZERO;
                return r;
            end
            for (int i = 0; i < NSLOTS; i++) begin
                if (!tbl_valid[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                r.ev = EV_FULL;
                return r;
            end
            tbl_valid[slot]  = 1'b1;
            tbl_number[slot] = sched_next_pid;
            tbl_prio[slot]   = prio;
            tbl_ready[slot]  = arrival;
            tbl_left[slot]   = burst;
            tbl_waited[slot] = '0;
            tbl_burst[slot]  = burst;
            tbl_stamp[slot]  = sched_next_stamp;
            sched_next_stamp++;
            r.ev  = EV_ADDED;
            r.pid = sched_next_pid;
            sched_next_pid++;
            return r;
        end
        // Pick the ready entry with the lowest priority number, oldest stamp first.
        best_prio = '0;
        best_age  = '0;
        for (int i = 0; i < NSLOTS; i++) begin
            if (tbl_valid[i] && tbl_ready[i] <= sched_now) begin
                age = tbl_stamp[i] - sched_next_stamp;
                if (slot < 0 || tbl_prio[i] < best_prio ||
                    (tbl_prio[i] == best_prio && age < best_age)) begin
                    slot      = i;
                    best_prio = tbl_prio[i];
                    best_age  = age;
                end
            end
        end
        sched_now = r.tick + 1;
        if (slot < 0) begin
            r.ev = EV_IDLE;
            return r;
        end
        tbl_waited[slot] = add_saturating(tbl_waited[slot], r.tick - tbl_ready[slot]);
        tbl_left[slot]--;
        r.pid = tbl_number[slot];
        if (tbl_left[slot] == 0) begin
            r.ev         = EV_DONE;
            r.waited     = tbl_waited[slot];
            r.turnaround = add_saturating(tbl_waited[slot], {16'd0, tbl_burst[slot]});
            tbl_valid[slot] = 1'b0;
        end else begin
            r.ev            = EV_RUN;
            tbl_ready[slot] = r.tick + 1;
            tbl_stamp[slot] = sched_next_stamp;
            sched_next_stamp++;
        end
        return r;
    endfunction

    // Offers one transaction, waits for acceptance and queues its expected result.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic func, logic [7:0] prio, logic [31:0] arrival,
                             logic [15:0] burst, bit has_exp, t_event ev,
                             logic [15:0] pid, logic [31:0] tick);
        t_completion r;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid        <= 1'b0;
            i_func         <= 1'($urandom);
            i_priority_req <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= func;
        i_priority_req <= prio;
        i_arrival_time <= arrival;
        i_burst        <= burst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = schedule_step(func, prio, arrival, burst);
        if (has_exp && (r.ev != ev || r.pid != pid || r.tick != tick)) begin
            $error("table row disagrees with prediction: ev %0d/%0d pid %0d/%0d tick %0d/%0d",
                   ev, r.ev, pid, r.pid, tick, r.tick);
            errors++;
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    // Stalls the output side at random, with one long hold-off on request.
    initial begin
        i_stall = 1'b1;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (drain_hold && !hold_done) begin
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compares each delivered result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: event %0d", o_event_res);
                errors++;
            end else begin
                t_completion e;
                e = pending_results.pop_front();
                if (o_event_res !== e.ev) begin
                    $error("event_res expected %0d actual %0d", e.ev, o_event_res);
                    errors++;
                end
                if (o_process_id !== e.pid) begin
                    $error("process_id expected %0d actual %0d", e.pid, o_process_id);
                    errors++;
                end
                if (o_tick_time !== e.tick) begin
                    $error("tick_time expected %0d actual %0d", e.tick, o_tick_time);
                    errors++;
                end
                if (o_waiting_time !== e.waited) begin
                    $error("waiting_time expected %0d actual %0d", e.waited, o_waiting_time);
                    errors++;
                end
                if (o_turnaround_time !== e.turnaround) begin
                    $error("turnaround_time expected %0d actual %0d",
                           e.turnaround, o_turnaround_time);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("[preemptive_priority_scheduler] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row        rows [$];
        t_row        row;
        logic [31:0] arrival;
        logic [15:0] burst;
        int          kind;

        errors         = 0;
        quiet_cycles   = 0;
        drain_hold     = 1'b0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_ADD;
        i_priority_req = '0;
        i_arrival_time = '0;
        i_burst        = '0;
        clear_schedule();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: idle tick, zero burst, extremes, fill to full, then six ticks.
        rows.push_back('{FUNC_TICK, 8'd0, 32'd0, 16'd0, 1, EV_IDLE, 16'd0, 32'd0});
        rows.push_back('{FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 16'd0, 1, EV_ZERO, 16'd0, 32'd1});
        rows.push_back('{FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1, EV_ADDED, 16'd1, 32'd1});
        rows.push_back('{FUNC_ADD, 8'd0, 32'd0, 16'd1, 1, EV_ADDED, 16'd2, 32'd1});
        rows.push_back('{FUNC_ADD, 8'd5, 32'd1, 16'd2, 1, EV_ADDED, 16'd3, 32'd1});
        rows.push_back('{FUNC_ADD, 8'd5, 32'd0, 16'd2, 1, EV_ADDED, 16'd4, 32'd1});
        for (int i = 0; i < 12; i++)
            rows.push_back('{FUNC_ADD, 8'(i), 32'd3, 16'(i + 1), 0, EV_ADDED, 16'd0, 32'd0});
        rows.push_back('{FUNC_ADD, 8'd1, 32'd0, 16'd1, 1, EV_FULL, 16'd0, 32'd1});
        for (int i = 0; i < 6; i++)
            rows.push_back('{FUNC_TICK, 8'hAA, 32'h5555_5555, 16'hAAAA, 0,
                             EV_IDLE, 16'd0, 32'd0});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.func, row.prio, row.arrival, row.burst, row.has_exp,
                      row.ev, row.pid, row.tick);
        end

        // Random part: mostly small bursts near the current time, some noise.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle    = (n >= 600 && n < 800);
            drain_hold = (n >= 1000);
            kind       = $urandom_range(99);
            if (kind < 45) begin
                arrival = sched_now + $urandom_range(6) - 2;
                burst   = 16'($urandom_range(1, 6));
                if (kind < 3) burst = 16'd0;
                if (kind == 3) burst = 16'($urandom);
                if (kind == 4) arrival = $urandom;
                send_item(FUNC_ADD,
                          8'($urandom_range(3) * ($urandom_range(9) == 0 ? 85 : 1)),
                          arrival, burst, 0, EV_IDLE, 16'd0, 32'd0);
            end else begin
                send_item(FUNC_TICK, 8'($urandom), $urandom, 16'($urandom), 0,
                          EV_IDLE, 16'd0, 32'd0);
            end
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then allow a short settling time.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * NSLOTS + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[preemptive_priority_scheduler] OK");
        end else begin
            $display("[preemptive_priority_scheduler] ERROR");
        end
        $finish;
    end

endmodule
